/* hdl/spdif_se_pkg.sv */
// Shared types, constants and coding functions of the S/PDIF subframe encoder.
package spdif_se_pkg;

	localparam int AUDIO_BITS     = 20;
	localparam int SAMPLE_W       = 20;
	localparam int AUX_W          = 4;
	localparam int WORD_SLOTS     = 24;
	localparam int FIRST_DATA     = 4;
	localparam int SLOTS          = 32;
	localparam int PRE_CELLS      = 8;
	localparam int CELLS          = 64;
	localparam int CELL_IDX_W     = $clog2(CELLS);
	localparam int AUX_SLOTS      = (AUDIO_BITS >= WORD_SLOTS) ? 0 : WORD_SLOTS - AUDIO_BITS;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(CELLS - 1);

	localparam logic [1:0] PRE_B = 2'd0;
	localparam logic [1:0] PRE_M = 2'd1;
	localparam logic [1:0] PRE_W = 2'd2;

	// Bit i set: preamble half-cell i sits at the inverted start level.
	localparam logic [PRE_CELLS-1:0] PAT_B = 8'h17;
	localparam logic [PRE_CELLS-1:0] PAT_M = 8'h47;
	localparam logic [PRE_CELLS-1:0] PAT_W = 8'h27;

	typedef struct packed {
		logic [1:0]          preamble_kind;
		logic [AUX_W-1:0]    aux_bits;
		logic [SAMPLE_W-1:0] audio_sample;
		logic                validity_bit;
		logic                user_bit;
		logic                status_bit;
	} subframe_t;

	typedef struct packed {
		logic                  line_level;
		logic [CELL_IDX_W-1:0] half_cell_index;
		logic                  last_cell;
	} cell_t;

	// One classified subframe as it waits between front and back.
	typedef struct packed {
		logic [PRE_CELLS-1:0] pattern;
		logic [SLOTS-1:0]     slots;
	} entry_t;

	function automatic logic [PRE_CELLS-1:0] preamble_pattern(input logic [1:0] kind);
		logic [PRE_CELLS-1:0] pat;
		unique case (kind)
			PRE_B:   pat = PAT_B;
			PRE_W:   pat = PAT_W;
			default: pat = PAT_M;
		endcase
		return pat;
	endfunction

	// Aux bits fill the low slots of the 24-slot word, the audio sample the top.
	function automatic logic [WORD_SLOTS-1:0] build_word(input logic [AUX_W-1:0] aux,
			input logic [SAMPLE_W-1:0] audio);
		logic [WORD_SLOTS-1:0] w;
		w = '0;
		for (int i = 0; i < WORD_SLOTS; i++) begin
			if (i < AUX_SLOTS) begin
				if (i < AUX_W)
					w[i] = aux[i];
			end else if ((i - AUX_SLOTS) < SAMPLE_W && (i - AUX_SLOTS) < AUDIO_BITS) begin
				w[i] = audio[i - AUX_SLOTS];
			end
		end
		return w;
	endfunction

endpackage

/* hdl/spdif_se_front.sv */
// Front end: turns an incoming subframe into a preamble pattern and a slot vector.
module spdif_se_front (
	input  spdif_se_pkg::subframe_t sub,
	output spdif_se_pkg::entry_t    entry
);
	import spdif_se_pkg::*;

	logic [WORD_SLOTS-1:0] word;
	logic                  parity;

	always_comb begin
		word   = build_word(sub.aux_bits, sub.audio_sample);
		parity = ^word ^ sub.validity_bit ^ sub.user_bit ^ sub.status_bit;
		entry.pattern = preamble_pattern(sub.preamble_kind);
		entry.slots   = {parity, sub.status_bit, sub.user_bit, sub.validity_bit, word,
			FIRST_DATA'(0)};
	end

endmodule

/* hdl/spdif_se_queue.sv */
// Two-entry queue between the front end and the serialiser.
module spdif_se_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  spdif_se_pkg::entry_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output spdif_se_pkg::entry_t pop_data
);
	import spdif_se_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	entry_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
	a_pop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(full && do_pop && !do_push) |=> (count_q == (PTR_W+1)'(QUEUE_DEPTH - 1)))
		else $error("queue count wrong after pop");
`endif

endmodule

/* hdl/spdif_se_back.sv */
// Back end: serialises one queued subframe into 64 biphase-mark half-cells.
module spdif_se_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  spdif_se_pkg::entry_t q_data,
	output logic                 q_pop,
	output logic                 cell_valid,
	input  logic                 cell_ready,
	output spdif_se_pkg::cell_t  half_cell
);
	import spdif_se_pkg::*;

	logic                    busy_q;
	logic [CELL_IDX_W-1:0]   cnt_q;
	logic [PRE_CELLS-1:0]    pat_q;
	logic [SLOTS-1:0]        slots_q;
	logic                    level_q;
	logic                    start_q;
	logic                    cell_valid_q;
	cell_t                   cell_q;
	logic                    adv;
	logic                    load;
	logic                    slot_bit;
	logic                    cell_level;

	always_comb begin
		adv      = !cell_valid_q || cell_ready;
		load     = !busy_q || (adv && cnt_q == LAST_CELL);
		q_pop    = load && q_valid;
		slot_bit = slots_q[cnt_q[CELL_IDX_W-1:1]];
		if (cnt_q < CELL_IDX_W'(PRE_CELLS))
			cell_level = start_q ^ pat_q[cnt_q[$clog2(PRE_CELLS)-1:0]];
		else if (!cnt_q[0])
			cell_level = !level_q;
		else
			cell_level = level_q ^ slot_bit;
	end

	always_ff @(posedge clk) begin
		if (adv && busy_q) begin
			cell_q.line_level      <= cell_level;
			cell_q.half_cell_index <= cnt_q;
			cell_q.last_cell       <= (cnt_q == LAST_CELL);
		end
		if (q_pop) begin
			pat_q   <= q_data.pattern;
			slots_q <= q_data.slots;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cnt_q        <= '0;
			level_q      <= 1'b0;
			start_q      <= 1'b0;
			cell_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				cell_valid_q <= busy_q;
				if (busy_q) begin
					level_q <= cell_level;
					cnt_q   <= cnt_q + 1'b1;
				end
			end
			if (load) begin
				busy_q <= q_valid;
				if (q_valid)
					start_q <= busy_q ? cell_level : level_q;
			end
		end
	end

	assign cell_valid = cell_valid_q;
	assign half_cell  = cell_q;

`ifndef SYNTH
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0))
		else $error("cell counter moved while idle");
	a_parity_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && cnt_q == LAST_CELL) |-> (cell_level == start_q))
		else $error("subframe did not end at its starting level");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid_q && cell_q.last_cell) |-> (cell_q.half_cell_index == LAST_CELL))
		else $error("last marker on wrong half-cell");
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && adv && cnt_q != LAST_CELL) |=> busy_q)
		else $error("serialiser stopped inside a subframe");
`endif

endmodule

/* hdl/spdif_subframe_encoder.sv */
// From idle a subframe is queued, then loaded, then its first half-cell registered.
// Throughput: one half-cell per cycle while cell_ready is high and a subframe waits.
// A two-entry queue lets new subframes be taken while the serialiser is still busy.
// Reset (arst_n low, asynchronous) empties the queue, drops any pending half-cell and
// sets the carried line level to low.
module spdif_subframe_encoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      subframe_valid,
	output logic                      subframe_ready,
	input  spdif_se_pkg::subframe_t   subframe,
	output logic                      cell_valid,
	input  logic                      cell_ready,
	output spdif_se_pkg::cell_t       half_cell
);
	import spdif_se_pkg::*;

	// Classified subframe straight from the front end.
	entry_t front_entry;
	// Head of the queue as seen by the serialiser.
	entry_t head_entry;
	logic   q_full;
	logic   q_not_empty;
	logic   q_pop;

	// The front end is pure logic: it picks the preamble run pattern, lays the
	// aux bits and audio word into slots 4 to 27 LSB first, and works out the
	// even parity over slots 4 to 30 so the entry is ready to queue.
	spdif_se_front u_front (
		.sub   (subframe),
		.entry (front_entry)
	);

	// A transfer in happens whenever the queue has room, independent of how
	// far the serialiser has got with the subframe ahead.
	assign subframe_ready = !q_full;

	spdif_se_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (subframe_valid),
		.push_data (front_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (head_entry)
	);

	// The serialiser walks the 64 half-cells, carrying the line level from one
	// subframe to the next, and drives a registered output. While a transfer out
	// is stalled the serialiser holds its place, so the queue fills and
	// subframe_ready drops once both entries are taken.
	spdif_se_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_data     (head_entry),
		.q_pop      (q_pop),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.half_cell  (half_cell)
	);

endmodule

/* tb/sv/spdif_subframe_encoder_tb.sv */
// Self-checking testbench for the S/PDIF subframe encoder against a biphase-mark predictor.
`timescale 1ns / 1ps

module spdif_subframe_encoder_tb;
	import spdif_se_pkg::*;

	// Code 3 is not a real preamble. The encoder must treat it as M.
	localparam logic [1:0] PRE_UNUSED = 2'd3;

	// The aux bits take the word slots below the audio sample. Anything beyond four is zero.
	localparam int AUX_SLOT_COUNT = (AUDIO_BITS >= WORD_SLOTS) ? 0 : WORD_SLOTS - AUDIO_BITS;
	localparam logic [AUX_W-1:0] AUX_KEEP = (AUX_SLOT_COUNT >= AUX_W) ? '1
		: AUX_W'((1 << AUX_SLOT_COUNT) - 1);

	localparam int MAX_REPORTED   = 10;
	localparam int LONG_HOLD_CYCS = 600;
	localparam int DRAIN_CYCS     = 8;

	// One row of stimulus. Where golden_levels is valid, bit i is the line level that
	// half-cell i must carry. Otherwise the predictor supplies the expected levels.
	typedef struct packed {
		logic             has_golden;
		logic [CELLS-1:0] golden_levels;
		subframe_t        item;
	} stim_row_t;

	// Directed table. The first three rows follow reset with the line low. Each of them
	// also ends low, so their levels can be written out by hand. For example, an all-zero
	// payload alternates pairs of half-cells (0x33 per byte). An all-one payload has odd
	// parity, so every slot gets a mid-cell transition (0x55 per byte).
	localparam int DIRECTED_COUNT = 21;
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		{1'b1, 64'h3333_3333_3333_3317, PRE_B, 4'h0, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b1, 64'h5555_5555_5555_5527, PRE_W, 4'hF, 20'hFFFFF, 1'b1, 1'b1, 1'b1},
		{1'b1, 64'h3333_3333_3333_3347, PRE_M, 4'h0, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_UNUSED, 4'h0, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_M,      4'h1, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_W,      4'h8, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_M,      4'h0, 20'h00001, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_W,      4'h0, 20'h80000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_M,      4'h0, 20'h00000, 1'b1, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_W,      4'h0, 20'h00000, 1'b0, 1'b1, 1'b0},
		{1'b0, 64'h0, PRE_B,      4'h0, 20'h00000, 1'b0, 1'b0, 1'b1},
		{1'b0, 64'h0, PRE_W,      4'h0, 20'h00000, 1'b1, 1'b1, 1'b1},
		{1'b0, 64'h0, PRE_M,      4'h5, 20'hAAAAA, 1'b0, 1'b1, 1'b0},
		{1'b0, 64'h0, PRE_W,      4'hA, 20'h55555, 1'b1, 1'b0, 1'b1},
		{1'b0, 64'h0, PRE_M,      4'h0, 20'hFFFFF, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_B,      4'hF, 20'hFFFFF, 1'b1, 1'b1, 1'b1},
		{1'b0, 64'h0, PRE_M,      4'hF, 20'hFFFFF, 1'b1, 1'b1, 1'b1},
		{1'b0, 64'h0, PRE_UNUSED, 4'hF, 20'hFFFFF, 1'b1, 1'b1, 1'b1},
		{1'b0, 64'h0, PRE_W,      4'h0, 20'h00000, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_B,      4'h0, 20'h00001, 1'b0, 1'b0, 1'b0},
		{1'b0, 64'h0, PRE_M,      4'hF, 20'h00000, 1'b0, 1'b0, 1'b1}
	};

	logic      clk            = 1'b0;
	logic      arst_n         = 1'b0;
	logic      subframe_valid = 1'b0;
	logic      subframe_ready;
	subframe_t subframe       = '0;
	logic      cell_valid;
	logic      cell_ready     = 1'b0;
	cell_t     half_cell;

	// The main sequence owns these knobs. It only writes them on the falling edge.
	int   sender_idle_pct = 0;
	int   recv_stall_pct  = 0;
	logic long_hold       = 1'b0;

	stim_row_t        subframes_to_send [$];
	cell_t            expected_cells [$];
	int               error_count = 0;
	stim_row_t        offered_row;
	logic [CELLS-1:0] predicted_levels;
	logic             line_state = 1'b0;

	spdif_subframe_encoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.subframe_valid (subframe_valid),
		.subframe_ready (subframe_ready),
		.subframe       (subframe),
		.cell_valid     (cell_valid),
		.cell_ready     (cell_ready),
		.half_cell      (half_cell)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Returns the 64 half-cell levels of one subframe, given the line level that the
	// previous subframe left behind. The new line level is the level of the last half-cell.
	function automatic logic [CELLS-1:0] encode_subframe(input subframe_t sf,
			input logic start_level);
		logic [PRE_CELLS-1:0]  pattern;
		logic [WORD_SLOTS-1:0] word;
		logic [SLOTS-1:0]      slot_bits;
		logic [CELLS-1:0]      levels;
		logic                  lvl;
		case (sf.preamble_kind)
			PRE_B:   pattern = PAT_B;
			PRE_W:   pattern = PAT_W;
			default: pattern = PAT_M;
		endcase
		word = (WORD_SLOTS'(sf.audio_sample) << AUX_SLOT_COUNT)
			| WORD_SLOTS'(sf.aux_bits & AUX_KEEP);
		slot_bits = {1'b0, sf.status_bit, sf.user_bit, sf.validity_bit, word, 4'b0000};
		// The parity slot makes the count of ones in slots 4 to 31 even.
		slot_bits[SLOTS-1] = ^slot_bits[SLOTS-2:FIRST_DATA];
		for (int i = 0; i < PRE_CELLS; i++)
			levels[i] = start_level ^ pattern[i];
		// Every preamble ends at the level that it started from.
		lvl = start_level;
		for (int s = FIRST_DATA; s < SLOTS; s++) begin
			lvl = ~lvl;
			levels[2*s] = lvl;
			if (slot_bits[s])
				lvl = ~lvl;
			levels[2*s+1] = lvl;
		end
		return levels;
	endfunction

	task automatic queue_expected_cells(input logic [CELLS-1:0] levels);
		cell_t c;
		for (int i = 0; i < CELLS; i++) begin
			c.line_level      = levels[i];
			c.half_cell_index = CELL_IDX_W'(i);
			c.last_cell       = (i == CELLS - 1);
			expected_cells.push_back(c);
		end
	endtask

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTED)
			$display("%s", msg);
	endtask

	// Subframe sender. When a transfer completes, the encoded half-cells of that subframe
	// become expectations, and the predicted line level carries over to the next one.
	// Valid is never lowered before its transfer has happened.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subframe_valid <= 1'b0;
			subframe       <= '0;
			line_state     = 1'b0;
		end else begin
			if (subframe_valid && subframe_ready) begin
				predicted_levels = encode_subframe(subframe, line_state);
				line_state = predicted_levels[CELLS-1];
				queue_expected_cells(offered_row.has_golden ? offered_row.golden_levels
					: predicted_levels);
			end
			if (!subframe_valid || subframe_ready) begin
				if (subframes_to_send.size() != 0
						&& $urandom_range(99) >= sender_idle_pct) begin
					offered_row = subframes_to_send.pop_front();
					subframe_valid <= 1'b1;
					subframe       <= offered_row.item;
				end else begin
					subframe_valid <= 1'b0;
				end
			end
		end
	end

	// Half-cell receiver. Each transfer is compared field by field with the oldest
	// expectation. The long hold keeps ready low so that the encoder backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_ready <= 1'b0;
		end else begin
			if (cell_valid && cell_ready) begin
				if (expected_cells.size() == 0) begin
					note_error($sformatf("unexpected half-cell: level %0b index %0d last %0b",
						half_cell.line_level, half_cell.half_cell_index, half_cell.last_cell));
				end else begin
					cell_t want;
					want = expected_cells.pop_front();
					if (half_cell.line_level !== want.line_level)
						note_error($sformatf("line_level at cell %0d: expected %0b, got %0b",
							want.half_cell_index, want.line_level, half_cell.line_level));
					if (half_cell.half_cell_index !== want.half_cell_index)
						note_error($sformatf("half_cell_index: expected %0d, got %0d",
							want.half_cell_index, half_cell.half_cell_index));
					if (half_cell.last_cell !== want.last_cell)
						note_error($sformatf("last_cell at cell %0d: expected %0b, got %0b",
							want.half_cell_index, want.last_cell, half_cell.last_cell));
				end
			end
			cell_ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic stim_row_t random_subframe();
		stim_row_t r;
		r.has_golden              = 1'b0;
		r.golden_levels           = '0;
		r.item.preamble_kind      = 2'($urandom_range(3));
		r.item.aux_bits           = AUX_W'($urandom);
		r.item.audio_sample       = SAMPLE_W'($urandom);
		r.item.validity_bit       = 1'($urandom_range(1));
		r.item.user_bit           = 1'($urandom_range(1));
		r.item.status_bit         = 1'($urandom_range(1));
		return r;
	endfunction

	// Waits until every queued subframe has been transferred and every half-cell has come
	// back. The sender then has nothing left to offer, so each phase starts from an empty encoder.
	task automatic wait_until_drained();
		while (subframes_to_send.size() != 0 || subframe_valid)
			@(negedge clk);
		while (expected_cells.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random_phase(input int count, input int send_idle, input int recv_stall);
		sender_idle_pct = send_idle;
		recv_stall_pct  = recv_stall;
		for (int i = 0; i < count; i++)
			subframes_to_send.push_back(random_subframe());
		wait_until_drained();
	endtask

	// Main sequence: the directed table first, then random subframes under each idling
	// pattern, then a long receiver hold-off while the sender keeps offering transfers.
	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			subframes_to_send.push_back(DIRECTED_ROWS[i]);
		wait_until_drained();

		run_random_phase(80, 0, 0);
		run_random_phase(80, 53, 0);
		run_random_phase(80, 0, 53);
		run_random_phase(80, 15, 15);

		// Fill the encoder queue and hold the receiver off. Ready on the subframe side has
		// to drop, and the backlog has to come out intact once the hold lifts.
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		for (int i = 0; i < 70; i++)
			subframes_to_send.push_back(random_subframe());
		long_hold = 1'b1;
		repeat (LONG_HOLD_CYCS) @(negedge clk);
		long_hold = 1'b0;
		wait_until_drained();

		// Give any stray half-cell a chance to show up before the verdict.
		repeat (DRAIN_CYCS) @(negedge clk);
		if (error_count == 0 && expected_cells.size() == 0) begin
			$display("spdif_subframe_encoder_tb passed");
		end else begin
			$display("spdif_subframe_encoder_tb failed");
		end
		$finish;
	end

	// Overall limit. A correct run needs well under a tenth of this.
	initial begin
		#(10_000_000);
		$display("spdif_subframe_encoder_tb failed");
		$finish;
	end

endmodule
